// ===== src/pkrmv_pkg.sv =====
package pkrmv_pkg;

  localparam int SYM_W     = 8;
  localparam int PRICE_W   = 40;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 64;
  localparam int PROD_W    = 2 * PRICE_W;
  localparam int MUL_CHUNK = PRICE_W / 2;

  // one table row: count, mean and sum of squared deviations
  typedef struct packed {
    logic [SUM_W-1:0]   sumsq;
    logic [PRICE_W-1:0] mean;
    logic [CNT_W-1:0]   count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/pkrmv_mem.sv =====
module pkrmv_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 136
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/pkrmv_div.sv =====
module pkrmv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pkrmv_pkg::PRICE_W-1:0] dividend,
  input  logic [pkrmv_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [pkrmv_pkg::PRICE_W-1:0] quotient
);
  import pkrmv_pkg::*;

  localparam int STEP_W = $clog2(PRICE_W);

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [PRICE_W-1:0] quo_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   dvs_r;

  // restoring radix-2 step: shift one dividend bit into the remainder
  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           fits;

  always_comb begin
    trial = {rem_r, quo_r[PRICE_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_r <= {quo_r[PRICE_W-2:0], fits};
        if (step_r == STEP_W'(PRICE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !$past(start)) |-> rem_r < dvs_r)
    else $error("partial remainder not below divisor");
`endif

endmodule

// ===== src/pkrmv_mul.sv =====
module pkrmv_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pkrmv_pkg::PRICE_W-1:0] mul_a,
  input  logic [pkrmv_pkg::PRICE_W-1:0] mul_b,
  output logic                          done,
  output logic [pkrmv_pkg::PROD_W-1:0]  product
);
  import pkrmv_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 step_r;
  logic [PRICE_W-1:0]   a_r;
  logic [PRICE_W-1:0]   b_r;
  logic [PROD_W-1:0]    acc_r;

  // one 40x20 partial product per cycle, low half then high half
  logic [MUL_CHUNK-1:0]         chunk;
  logic [PRICE_W+MUL_CHUNK-1:0] pp;
  logic [PROD_W-1:0]            pp_ext;

  always_comb begin
    chunk  = step_r ? b_r[PRICE_W-1:MUL_CHUNK] : b_r[MUL_CHUNK-1:0];
    pp     = a_r * chunk;
    pp_ext = PROD_W'(pp);
    if (step_r) begin
      pp_ext = pp_ext << MUL_CHUNK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
        a_r    <= mul_a;
        b_r    <= mul_b;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r  <= acc_r + pp_ext;
        step_r <= 1'b1;
        if (step_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== src/per_key_running_mean_variance.sv =====
// per-symbol running mean and variance (welford update), one word in, one word out
//
// in channel: in_tdata carries a symbol index and an unsigned q24.16 price.
// out channel: out_tdata carries the symbol index, the updated sample count
// (saturating), the updated mean and the updated sum of squared deviations
// (16 fraction bits by default, saturating at all ones).
// an index at or beyond NUM_SYMBOLS changes nothing and returns zero statistics.
//
// the statistics of all symbols sit in one synchronous table, read once and
// written back once per in-range word; only one word is in flight, so no forwarding.
// an in-range word goes through table read, a 40-step radix-2 divider for the
// mean step (the longest step), a multiply split into low and high halves,
// shift and saturating add, and write back into the table and output register.
// out-of-range words go straight from acceptance to the output register.
// in_tready is high only while the engine is idle.
//
// after reset the table is cleared one row a cycle, all NUM_SYMBOLS rows, with
// in_tready low. a result waits in the output register while the receiver
// stalls; the next word can be taken and worked on meanwhile, and it holds at
// the write-back step until the output register is free.
module per_key_running_mean_variance #(
  parameter int NUM_SYMBOLS = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // symbol_index[7:0], price[47:8]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // symbol_out[7:0], sample_count[39:8],
                                   // running_mean[79:40], sum_sq_dev[143:80]
);
  import pkrmv_pkg::*;

  localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam logic [16:0] NSYM = 17'(NUM_SYMBOLS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_DIV, S_MEAN, S_MUL, S_SAT, S_ADD, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // input word split
  logic [SYM_W-1:0]   in_sym;
  logic [PRICE_W-1:0] in_price;
  logic               in_acc;
  logic               in_range;
  logic [AW+SYM_W-1:0] sym_ext;

  assign in_sym   = in_tdata[SYM_W-1:0];
  assign in_price = in_tdata[SYM_W+PRICE_W-1:SYM_W];
  assign in_acc   = in_tvalid && in_tready;
  assign in_range = {9'b0, in_sym} < NSYM;
  assign sym_ext  = {{AW{1'b0}}, in_sym};

  // item registers
  logic [SYM_W-1:0]   sym_r;
  logic [AW-1:0]      addr_r;
  logic               range_r;
  logic [PRICE_W-1:0] price_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PRICE_W-1:0] mean_r;
  logic [SUM_W-1:0]   sum_r;
  logic               neg_r;
  logic [PRICE_W-1:0] dold_r;
  logic [PRICE_W-1:0] q_r;
  logic [PRICE_W-1:0] mean_upd_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SUM_W-1:0]   inc_r;
  logic [SUM_W-1:0]   sum_new_r;
  logic [AW-1:0]      clr_addr_r;

  // output register
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_sym_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [PRICE_W-1:0] out_mean_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_load;

  // table
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        rd_entry;
  logic [ENTRY_W-1:0] rd_raw;

  pkrmv_mem #(
    .DEPTH (NUM_SYMBOLS),
    .AW    (AW),
    .W     (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (in_acc),
    .rd_addr (sym_ext[AW-1:0]),
    .rd_data (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // load stage: count step, sign and magnitude of the old deviation
  logic [CNT_W-1:0]   cnt_inc;
  logic               neg;
  logic [PRICE_W-1:0] dold;

  always_comb begin
    cnt_inc = (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 1'b1;
    neg     = price_r < rd_entry.mean;
    dold    = neg ? rd_entry.mean - price_r : price_r - rd_entry.mean;
  end

  logic               div_done;
  logic [PRICE_W-1:0] div_q;

  pkrmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_LOAD),
    .dividend (dold),
    .divisor  (cnt_inc),
    .done     (div_done),
    .quotient (div_q)
  );

  // mean stage: new mean and new deviation
  logic [PRICE_W-1:0] mean_upd;
  logic [PRICE_W-1:0] dnew;

  always_comb begin
    mean_upd = neg_r ? mean_r - q_r : mean_r + q_r;
    dnew     = neg_r ? mean_upd - price_r : price_r - mean_upd;
  end

  logic              mul_done;
  logic [PROD_W-1:0] mul_p;

  pkrmv_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_MEAN),
    .mul_a   (dnew),
    .mul_b   (dold_r),
    .done    (mul_done),
    .product (mul_p)
  );

  // drop fraction bits, saturate, then saturating add
  logic [PROD_W-1:0] prod_sh;
  logic [SUM_W-1:0]  inc_sat;
  logic [SUM_W:0]    sum_wide;

  always_comb begin
    prod_sh  = prod_r >> FRAC_BITS;
    inc_sat  = (|prod_sh[PROD_W-1:SUM_W]) ? '1 : prod_sh[SUM_W-1:0];
    sum_wide = {1'b0, sum_r} + {1'b0, inc_r};
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '{sumsq: sum_new_r, mean: mean_upd_r, count: cnt_r};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (out_load && range_r) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == AW'(NUM_SYMBOLS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = in_range ? S_LOAD : S_DONE;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_MEAN;
      S_MEAN:  state_nxt = S_MUL;
      S_MUL:   if (mul_done) state_nxt = S_SAT;
      S_SAT:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (in_acc) begin
        sym_r   <= in_sym;
        addr_r  <= sym_ext[AW-1:0];
        range_r <= in_range;
        price_r <= in_price;
      end
      if (state_r == S_LOAD) begin
        cnt_r  <= cnt_inc;
        mean_r <= rd_entry.mean;
        sum_r  <= rd_entry.sumsq;
        neg_r  <= neg;
        dold_r <= dold;
      end
      if (state_r == S_DIV && div_done) begin
        q_r <= div_q;
      end
      if (state_r == S_MEAN) begin
        mean_upd_r <= mean_upd;
      end
      if (state_r == S_MUL && mul_done) begin
        prod_r <= mul_p;
      end
      if (state_r == S_SAT) begin
        inc_r <= inc_sat;
      end
      if (state_r == S_ADD) begin
        sum_new_r <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_sym_r   <= sym_r;
        out_cnt_r   <= range_r ? cnt_r : '0;
        out_mean_r  <= range_r ? mean_upd_r : '0;
        out_sum_r   <= range_r ? sum_new_r : '0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sum_r, out_mean_r, out_cnt_r, out_sym_r};

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider result outside the divide step");
  a_write_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_DONE))
    else $error("table write outside clear or write back");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word appeared without write back");
  a_mean_between: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (neg_r ? (mean_upd_r <= mean_r && mean_upd_r >= price_r)
                                  : (mean_upd_r >= mean_r && mean_upd_r <= price_r)))
    else $error("new mean outside old mean and price");
`endif

endmodule
